// File: sv/assert_macros.svh
// assertion helpers for the alu checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every edge out of reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: sv/u128alu_pkg.sv
// ----------------------------------------------------------------------------
// u128alu_pkg
// types and operation codes of the 128-bit unsigned alu
// ----------------------------------------------------------------------------
`default_nettype none

package u128alu_pkg;

    localparam logic [2:0] FN_ADD = 3'd0;
    localparam logic [2:0] FN_SUB = 3'd1;
    localparam logic [2:0] FN_MUL = 3'd2;
    localparam logic [2:0] FN_DIV = 3'd3;
    localparam logic [2:0] FN_CMP = 3'd4;

    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] a_high;
        logic [63:0] a_low;
        logic [63:0] b_high;
        logic [63:0] b_low;
    } req_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
        logic [31:0] remainder;
        logic        less_than;
        logic        equal;
        logic        divide_by_zero;
    } rsp_t;

endpackage

`default_nettype wire

// File: sv/u128alu_chan.sv
// ----------------------------------------------------------------------------
// u128alu_chan
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
`default_nettype none

interface u128alu_chan #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/uint128_alu.sv
// ----------------------------------------------------------------------------
// uint128_alu
// pipelined 128-bit unsigned add, subtract, multiply, divide by 32 bits, compare
// ----------------------------------------------------------------------------
// channel  dir  payload
// req      in   func, a_high, a_low, b_high, b_low
// rsp      out  result_high, result_low, remainder, less_than, equal,
//               divide_by_zero
//
// one beat accepted per cycle while rsp is not stalled; 17 register stages
// the divider takes 16 stages of 8 quotient bits each
// multiply uses 32x32 partial products, column sums, then a final add
// a stall on rsp freezes the whole pipe; nothing is dropped or repeated
// reset clears only the valid bits
// ----------------------------------------------------------------------------
`default_nettype none

module uint128_alu (
    input  wire logic clk,
    input  wire logic rst_n,
    u128alu_chan.sink   req,
    u128alu_chan.source rsp
);
    import u128alu_pkg::*;
    `include "assert_macros.svh"

    localparam int NS = 17;

    logic          en;
    logic          vld_reg  [NS];
    logic [2:0]    fn_reg   [NS];
    logic [31:0]   d_reg    [NS];
    logic [127:0]  num_reg  [NS];
    logic [31:0]   rem_reg  [NS];
    logic [127:0]  res_reg  [NS];
    logic          lt_reg   [NS];
    logic          eq_reg   [NS];
    logic [127:0]  b_reg;
    logic [63:0]   p_reg    [4][4];
    logic [65:0]   col_reg  [4];

    logic [31:0]   rem_next [NS];
    logic [127:0]  num_next [NS];
    logic [63:0]   p_next   [4][4];
    logic [65:0]   col_next [4];
    logic [127:0]  mul_next;
    logic [127:0]  res1_next;
    logic [32:0]   r;
    logic [127:0]  q;

    assign en = !vld_reg[NS-1] || rsp.ready;
    assign req.ready = en;

    always_comb
    begin
        rem_next[0] = '0;
        num_next[0] = '0;
        for (int k = 1; k < NS; k++)
        begin
            r = {1'b0, rem_reg[k-1]};
            q = num_reg[k-1];
            for (int i = 0; i < 8; i++)
            begin
                r = {r[31:0], q[127]};
                q = {q[126:0], 1'b0};
                if (r >= {1'b0, d_reg[k-1]})
                begin
                    r = r - {1'b0, d_reg[k-1]};
                    q[0] = 1'b1;
                end
            end
            rem_next[k] = r[31:0];
            num_next[k] = q;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                if (i + j <= 3)
                    p_next[i][j] = 64'(num_reg[0][32*i +: 32]) * 64'(b_reg[32*j +: 32]);
                else
                    p_next[i][j] = '0;
            end
        end
        for (int k = 0; k < 4; k++)
        begin
            col_next[k] = '0;
            for (int i = 0; i <= k; i++)
                col_next[k] = col_next[k] + 66'(p_reg[i][k-i]);
        end
        mul_next = 128'(col_reg[0]) + (128'(col_reg[1]) << 32)
                 + (128'(col_reg[2]) << 64) + (128'(col_reg[3]) << 96);
        case (fn_reg[0])
            FN_ADD:  res1_next = num_reg[0] + b_reg;
            FN_SUB:  res1_next = num_reg[0] - b_reg;
            default: res1_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= req.valid;
            for (int k = 1; k < NS; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fn_reg[0]  <= req.data.func;
            d_reg[0]   <= req.data.b_low[31:0];
            num_reg[0] <= {req.data.a_high, req.data.a_low};
            rem_reg[0] <= '0;
            b_reg      <= {req.data.b_high, req.data.b_low};
            for (int k = 1; k < NS; k++)
            begin
                fn_reg[k]  <= fn_reg[k-1];
                d_reg[k]   <= d_reg[k-1];
                num_reg[k] <= num_next[k];
                rem_reg[k] <= rem_next[k];
            end
            res_reg[1] <= res1_next;
            lt_reg[1]  <= num_reg[0] < b_reg;
            eq_reg[1]  <= num_reg[0] == b_reg;
            for (int k = 2; k < NS; k++)
            begin
                lt_reg[k] <= lt_reg[k-1];
                eq_reg[k] <= eq_reg[k-1];
                if (k == 3 && fn_reg[2] == FN_MUL)
                    res_reg[k] <= mul_next;
                else
                    res_reg[k] <= res_reg[k-1];
            end
            p_reg   <= p_next;
            col_reg <= col_next;
        end
    end

    always_comb
    begin
        rsp.valid = vld_reg[NS-1];
        rsp.data  = '0;
        case (fn_reg[NS-1])
            FN_ADD, FN_SUB, FN_MUL:
            begin
                rsp.data.result_high = res_reg[NS-1][127:64];
                rsp.data.result_low  = res_reg[NS-1][63:0];
            end
            FN_DIV:
            begin
                if (d_reg[NS-1] == '0)
                    rsp.data.divide_by_zero = 1'b1;
                else
                begin
                    rsp.data.result_high = num_reg[NS-1][127:64];
                    rsp.data.result_low  = num_reg[NS-1][63:0];
                    rsp.data.remainder   = rem_reg[NS-1];
                end
            end
            FN_CMP:
            begin
                rsp.data.less_than = lt_reg[NS-1];
                rsp.data.equal     = eq_reg[NS-1];
            end
            default: rsp.data = '0;
        endcase
    end

    `ASSERT_IMPLY(a_lt_eq_excl, clk, rst_n, rsp.valid, !(rsp.data.less_than && rsp.data.equal))
    `ASSERT_IMPLY(a_dz_clean, clk, rst_n, rsp.valid && rsp.data.divide_by_zero, rsp.data.remainder == '0 && rsp.data.result_low == '0)
    `ASSERT_NEXT(a_stall_hold, clk, rst_n, vld_reg[NS-1] && !rsp.ready, vld_reg[NS-1] && $stable(num_reg[NS-1]) && $stable(res_reg[NS-1]))

endmodule

`default_nettype wire

// File: sim/tb_uint128_alu.sv
// ----------------------------------------------------------------------------
// tb_uint128_alu
// self-checking bench for the 128-bit unsigned alu: a directed table of
// operand corners, then random beats with random idling on both channels,
// every response compared field by field against a behavioral predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_uint128_alu;
    import u128alu_pkg::*;

    localparam int LATENCY = 17;
    localparam int N_RANDOM = 1000;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        req_t req;
        logic known;
        rsp_t rsp;
    } row_t;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   cycle_count;
    int   n_sent;
    int   n_checked;
    int   op_seen [8];
    logic quiet;
    rsp_t rsp_queue [$];
    row_t rows [$];

    u128alu_chan #(.payload_t(req_t)) req_ch ();
    u128alu_chan #(.payload_t(rsp_t)) rsp_ch ();

    uint128_alu DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic rsp_t alu_predict(req_t r);
        rsp_t        o;
        logic [127:0] a;
        logic [127:0] b;
        logic [127:0] v;
        logic [31:0]  d;
        a = {r.a_high, r.a_low};
        b = {r.b_high, r.b_low};
        o = '0;
        v = '0;
        case (r.func)
            FN_ADD: v = a + b;
            FN_SUB: v = a - b;
            FN_MUL: v = a * b;
            FN_DIV:
            begin
                d = r.b_low[31:0];
                if (d == 32'd0)
                    o.divide_by_zero = 1'b1;
                else
                begin
                    v = a / {96'd0, d};
                    o.remainder = 32'(a % {96'd0, d});
                end
            end
            FN_CMP:
            begin
                o.equal = (a == b);
                o.less_than = (a < b);
            end
            default: v = '0;
        endcase
        o.result_high = v[127:64];
        o.result_low = v[63:0];
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on beat %0d: %s got %h want %h", n_checked, what, got, want);
        mismatches++;
    endtask

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = ONES;
            2: v = 64'($urandom_range(0, 3));
            3: v = ONES - 64'($urandom_range(0, 3));
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    function automatic req_t rand_req();
        req_t r;
        int   k;
        k = $urandom_range(0, 39);
        r.func = (k < 38) ? 3'(k % 5) : 3'($urandom_range(5, 7));
        r.a_high = rand64();
        r.a_low = rand64();
        r.b_high = ($urandom_range(0, 3) == 0) ? r.a_high : rand64();
        r.b_low = ($urandom_range(0, 3) == 0) ? r.a_low : rand64();
        if (r.func == FN_DIV)
        begin
            case ($urandom_range(0, 5))
                0: r.b_low[31:0] = '0;
                1: r.b_low[31:0] = 32'($urandom_range(1, 15));
                2: r.b_low[31:0] = 32'hFFFF_FFFF;
                default: r.b_low[31:0] = $urandom;
            endcase
        end
        return r;
    endfunction

    function automatic row_t mk_row(logic [2:0] f, logic [63:0] ah, logic [63:0] al,
                                    logic [63:0] bh, logic [63:0] bl,
                                    logic known, rsp_t want);
        row_t t;
        t.req = '{func: f, a_high: ah, a_low: al, b_high: bh, b_low: bl};
        t.known = known;
        t.rsp = want;
        return t;
    endfunction

    initial
    begin
        rsp_t z;
        rsp_t w;
        z = '0;
        rows.push_back(mk_row(FN_ADD, 0, 0, 0, 0, 1, z));
        w = z; w.result_high = 0; w.result_low = 0;
        rows.push_back(mk_row(FN_ADD, ONES, ONES, 0, 1, 1, w));
        w = z; w.result_high = 1; w.result_low = 0;
        rows.push_back(mk_row(FN_ADD, 0, ONES, 0, 1, 1, w));
        w = z; w.result_high = ONES; w.result_low = ONES;
        rows.push_back(mk_row(FN_SUB, 0, 0, 0, 1, 1, w));
        rows.push_back(mk_row(FN_SUB, ONES, ONES, ONES, ONES, 1, z));
        rows.push_back(mk_row(FN_SUB, 1, 0, 0, 1, 0, z));
        w = z; w.result_high = 0; w.result_low = 1;
        rows.push_back(mk_row(FN_MUL, ONES, ONES, ONES, ONES, 1, w));
        rows.push_back(mk_row(FN_MUL, 0, ONES, 0, ONES, 0, z));
        rows.push_back(mk_row(FN_MUL, 64'h1234, ONES, ONES, 64'h5678, 0, z));
        rows.push_back(mk_row(FN_MUL, ONES, ONES, 0, 0, 1, z));
        w = z; w.divide_by_zero = 1;
        rows.push_back(mk_row(FN_DIV, ONES, ONES, ONES, 64'hFFFF_FFFF_0000_0000, 1, w));
        w = z; w.result_high = ONES; w.result_low = ONES;
        rows.push_back(mk_row(FN_DIV, ONES, ONES, ONES, 64'd1, 1, w));
        rows.push_back(mk_row(FN_DIV, ONES, ONES, 0, 64'hFFFF_FFFF, 0, z));
        rows.push_back(mk_row(FN_DIV, 64'h8000_0000_0000_0000, 64'd7, 0, 64'd3, 0, z));
        rows.push_back(mk_row(FN_DIV, 0, 64'd5, 0, 64'd7, 0, z));
        w = z; w.equal = 1;
        rows.push_back(mk_row(FN_CMP, ONES, ONES, ONES, ONES, 1, w));
        w = z; w.less_than = 1;
        rows.push_back(mk_row(FN_CMP, 0, ONES, 1, 0, 1, w));
        rows.push_back(mk_row(FN_CMP, 5, 2, 5, 1, 1, z));
        w = z; w.less_than = 1;
        rows.push_back(mk_row(FN_CMP, 5, 1, 5, 2, 1, w));
        rows.push_back(mk_row(3'd5, ONES, ONES, ONES, ONES, 1, z));
        rows.push_back(mk_row(3'd6, ONES, 1, 2, 3, 1, z));
        rows.push_back(mk_row(3'd7, ONES, ONES, ONES, ONES, 1, z));
    end

    // request side
    initial
    begin
        int   idle;
        row_t t;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rst_n = 1'b0;
        quiet = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (int i = 0; i < rows.size() + N_RANDOM; i++)
        begin
            if (i < rows.size())
                t = rows[i];
            else
            begin
                t.req = rand_req();
                t.known = 1'b0;
            end
            if (i > rows.size() + N_RANDOM - 150)
                quiet = 1'b1;
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                idle = $urandom_range(1, 19);
                req_ch.valid <= 1'b0;
                repeat (idle) @(negedge clk);
            end
            req_ch.valid <= 1'b1;
            req_ch.data <= t.req;
            @(posedge clk);
            while (!req_ch.ready) @(posedge clk);
            if (t.known && t.rsp != alu_predict(t.req))
                report_mismatch("table row", 64'(i), 0);
            rsp_queue.push_back(t.known ? t.rsp : alu_predict(t.req));
            op_seen[t.req.func]++;
            n_sent++;
            @(negedge clk);
        end
        req_ch.valid <= 1'b0;
        while (rsp_queue.size() != 0) @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
        $display("%0d beats sent, %0d responses checked", n_sent, n_checked);
        $display("ops add %0d sub %0d mul %0d div %0d cmp %0d other %0d", op_seen[0],
                 op_seen[1], op_seen[2], op_seen[3], op_seen[4],
                 op_seen[5] + op_seen[6] + op_seen[7]);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // response side ready
    initial
    begin
        int idle;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 7) == 0)
            begin
                idle = $urandom_range(1, 19);
                rsp_ch.ready <= 1'b0;
                repeat (idle) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        rsp_t got;
        rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = rsp_ch.data;
            if (rsp_queue.size() == 0)
                report_mismatch("unexpected response beat", 0, 0);
            else
            begin
                want = rsp_queue.pop_front();
                if (got.result_high !== want.result_high)
                    report_mismatch("result_high", got.result_high, want.result_high);
                if (got.result_low !== want.result_low)
                    report_mismatch("result_low", got.result_low, want.result_low);
                if (got.remainder !== want.remainder)
                    report_mismatch("remainder", 64'(got.remainder), 64'(want.remainder));
                if (got.less_than !== want.less_than)
                    report_mismatch("less_than", 64'(got.less_than), 64'(want.less_than));
                if (got.equal !== want.equal)
                    report_mismatch("equal", 64'(got.equal), 64'(want.equal));
                if (got.divide_by_zero !== want.divide_by_zero)
                    report_mismatch("divide_by_zero", 64'(got.divide_by_zero),
                                    64'(want.divide_by_zero));
            end
            n_checked++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
